/* hdl/svac_pkg.sv */
`default_nettype none

package svac_pkg;

  // Default sizing
  localparam int VOICE_COUNT_DEF = 12;
  localparam int CHUNK_STEP_DEF  = 64;

  // Fixed field widths
  localparam int MASK_W  = 12;
  localparam int SLOT_W  = 4;
  localparam int GAIN_W  = 15;
  localparam int POS_W   = 25;
  localparam int LEN_W   = 24;
  localparam int GRP_W   = 9;
  localparam int ADDR_W  = 32;
  localparam int NOTE_W  = 8;

  // Command codes
  localparam logic CMD_TRIGGER = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic signed [GRP_W-1:0] NO_GROUP = -9'sd1;
  localparam logic [6:0]              VEL_MAX  = 7'd127;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } seq_state_t;

  // One voice record as held in the voice memory
  typedef struct packed {
    logic [POS_W-1:0]         pos;
    logic [LEN_W-1:0]         len;
    logic signed [GRP_W-1:0]  grp;
    logic [ADDR_W-1:0]        addr;
    logic signed [NOTE_W-1:0] note;
    logic [15:0]              gain;
  } voice_rec_t;

  // Velocity curve in units of 1/10000
  typedef logic [13:0] tenk_tab_t [128];
  typedef logic [GAIN_W-1:0] gain_tab_t [128];

  localparam tenk_tab_t GAIN_TENK = '{
    14'd0, 14'd2, 14'd5, 14'd9, 14'd14, 14'd20, 14'd27, 14'd35,
    14'd44, 14'd54, 14'd65, 14'd76, 14'd88, 14'd100, 14'd113, 14'd128,
    14'd143, 14'd158, 14'd174, 14'd191, 14'd209, 14'd228, 14'd247, 14'd267,
    14'd287, 14'd308, 14'd330, 14'd353, 14'd377, 14'd401, 14'd426, 14'd452,
    14'd478, 14'd506, 14'd534, 14'd562, 14'd591, 14'd621, 14'd652, 14'd683,
    14'd715, 14'd748, 14'd781, 14'd815, 14'd850, 14'd886, 14'd921, 14'd958,
    14'd995, 14'd1033, 14'd1072, 14'd1112, 14'd1152, 14'd1193, 14'd1234, 14'd1276,
    14'd1319, 14'd1362, 14'd1406, 14'd1451, 14'd1497, 14'd1543, 14'd1590, 14'd1637,
    14'd1685, 14'd1733, 14'd1782, 14'd1832, 14'd1883, 14'd1934, 14'd1986, 14'd2039,
    14'd2092, 14'd2146, 14'd2200, 14'd2255, 14'd2311, 14'd2368, 14'd2425, 14'd2483,
    14'd2541, 14'd2601, 14'd2660, 14'd2721, 14'd2782, 14'd2844, 14'd2906, 14'd2970,
    14'd3033, 14'd3098, 14'd3163, 14'd3229, 14'd3295, 14'd3362, 14'd3430, 14'd3498,
    14'd3567, 14'd3636, 14'd3707, 14'd3778, 14'd3849, 14'd3922, 14'd3995, 14'd4068,
    14'd4143, 14'd4217, 14'd4293, 14'd4369, 14'd4446, 14'd4523, 14'd4601, 14'd4680,
    14'd4759, 14'd4839, 14'd4920, 14'd5001, 14'd5083, 14'd5165, 14'd5248, 14'd5332,
    14'd5416, 14'd5501, 14'd5587, 14'd5673, 14'd5760, 14'd5847, 14'd5935, 14'd8500
  };

  // Rounded Q0.15 conversion, evaluated at elaboration
  function automatic gain_tab_t build_gain_q15();
    gain_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = GAIN_W'((int'(GAIN_TENK[i]) * 32768 + 5000) / 10000);
    end
    return t;
  endfunction

  localparam gain_tab_t GAIN_Q15 = build_gain_q15();

endpackage

`default_nettype wire

/* hdl/svac_voice_mem.sv */
`default_nettype none

module svac_voice_mem #(
  parameter int VOICE_COUNT = svac_pkg::VOICE_COUNT_DEF,
  parameter int IDX_W       = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [IDX_W-1:0]        rd_addr,
  output svac_pkg::voice_rec_t         rd_data,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire svac_pkg::voice_rec_t    wr_data
);
  import svac_pkg::*;

  voice_rec_t mem [VOICE_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/svac_seq.sv */
`default_nettype none

module svac_seq #(
  parameter int VOICE_COUNT = svac_pkg::VOICE_COUNT_DEF,
  parameter int CHUNK_STEP  = svac_pkg::CHUNK_STEP_DEF,
  parameter int IDX_W       = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cmd,
  input  wire logic [31:0]           sample_base,
  input  wire logic [23:0]           sample_count,
  input  wire logic [7:0]            velocity,
  input  wire logic signed [7:0]     note_number,
  input  wire logic signed [8:0]     voice_group,
  input  wire logic signed [8:0]     choke_group,
  input  wire logic [3:0]            group_limit,
  input  wire logic                  silence_only,
  output logic                       done,
  output logic                       slot_valid,
  output logic [3:0]                 voice_slot,
  output logic                       stole_voice,
  output logic [14:0]                gain_q15,
  output logic                       any_active,
  output logic [11:0]                active_mask,
  output logic                       rd_en,
  output logic [IDX_W-1:0]           rd_addr,
  input  wire svac_pkg::voice_rec_t  rd_data,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_addr,
  output svac_pkg::voice_rec_t       wr_data
);
  import svac_pkg::*;

  localparam int CNT_W = $clog2(VOICE_COUNT + 1);
  localparam int NW    = (CNT_W > 4) ? CNT_W : 4;
  localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(VOICE_COUNT - 1);

  seq_state_t state, state_next;

  logic [IDX_W-1:0]       ptr, ptr_next;
  logic                   rd_vld, rd_vld_next;
  logic [IDX_W-1:0]       ridx, ridx_next;
  logic [VOICE_COUNT-1:0] on, on_next;

  // Latched request
  logic                   is_tick;
  logic [31:0]            r_base;
  logic [23:0]            r_count;
  logic [7:0]             r_vel;
  logic signed [7:0]      r_note;
  logic signed [8:0]      r_grp;
  logic signed [8:0]      r_choke;
  logic [3:0]             r_limit;
  logic                   r_silence;

  // Scan accumulators
  logic                   any, any_next;
  logic [CNT_W-1:0]       n, n_next;
  logic                   best_vld, best_vld_next;
  logic [IDX_W-1:0]       best, best_next;
  logic [POS_W-1:0]       best_pos, best_pos_next;
  logic [IDX_W-1:0]       steal, steal_next;
  logic [POS_W-1:0]       steal_pos, steal_pos_next;

  // Result registers
  logic                   done_next;
  logic                   slot_valid_next, stole_next, any_out_next;
  logic [3:0]             slot_next;
  logic [14:0]            gain_next;
  logic [VOICE_COUNT-1:0] mask_src;
  logic [11:0]            active_mask_next;

  // Finish-step helpers
  logic                   hit_choke, on_c, lim_ok, go, have_free;
  logic [POS_W-1:0]       pos_adv;
  logic [VOICE_COUNT-1:0] on_l;
  logic [IDX_W-1:0]       free_idx, target;
  logic [SW-1:0]          tgt_wide;
  logic [6:0]             vel_sat;

  assign busy    = (state != S_IDLE);
  assign rd_en   = (state == S_SCAN);
  assign rd_addr = ptr;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      on     <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
      on     <= on_next;
      done   <= done_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    ridx        <= ridx_next;
    any         <= any_next;
    n           <= n_next;
    best_vld    <= best_vld_next;
    best        <= best_next;
    best_pos    <= best_pos_next;
    steal       <= steal_next;
    steal_pos   <= steal_pos_next;
    slot_valid  <= slot_valid_next;
    voice_slot  <= slot_next;
    stole_voice <= stole_next;
    gain_q15    <= gain_next;
    any_active  <= any_out_next;
    active_mask <= active_mask_next;
    if (start && !busy) begin
      is_tick   <= (cmd == CMD_TICK);
      r_base    <= sample_base;
      r_count   <= sample_count;
      r_vel     <= velocity;
      r_note    <= note_number;
      r_grp     <= voice_group;
      r_choke   <= choke_group;
      r_limit   <= group_limit;
      r_silence <= silence_only;
    end
  end

  // First free voice after the limit cut
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!on_l[v]) begin
        have_free = 1'b1;
        free_idx  = IDX_W'(v);
      end
    end
  end

  // Mask port: voices above the twelfth are not shown
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < VOICE_COUNT) begin : g_on
      assign active_mask_next[b] = mask_src[b];
    end else begin : g_off
      assign active_mask_next[b] = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    rd_vld_next     = 1'b0;
    ridx_next       = ptr;
    on_next         = on;
    any_next        = any;
    n_next          = n;
    best_vld_next   = best_vld;
    best_next       = best;
    best_pos_next   = best_pos;
    steal_next      = steal;
    steal_pos_next  = steal_pos;
    done_next       = 1'b0;
    slot_valid_next = slot_valid;
    slot_next       = voice_slot;
    stole_next      = stole_voice;
    gain_next       = gain_q15;
    any_out_next    = any_active;
    mask_src        = on;
    wr_en           = 1'b0;
    wr_addr         = ridx;
    wr_data         = rd_data;

    hit_choke = on[ridx] && (r_choke != NO_GROUP) && (rd_data.grp == r_choke);
    on_c      = on[ridx] && !hit_choke;
    pos_adv   = rd_data.pos + POS_W'(CHUNK_STEP);

    lim_ok = (r_grp != NO_GROUP) && (r_limit != 4'd0) && best_vld &&
             (NW'(n) >= NW'(r_limit));
    on_l = on;
    if (lim_ok) begin
      on_l[best] = 1'b0;
    end
    go       = !r_silence && (r_base != 32'd0) && (r_count != 24'd0);
    target   = have_free ? free_idx : steal;
    tgt_wide = SW'(target);
    vel_sat  = r_vel[7] ? VEL_MAX : r_vel[6:0];

    // Entry returned by the memory
    if (rd_vld) begin
      if (is_tick) begin
        if (on[ridx] && (rd_data.addr != 32'd0)) begin
          any_next    = 1'b1;
          wr_en       = 1'b1;
          wr_data.pos = pos_adv;
          if (pos_adv >= {1'b0, rd_data.len}) begin
            on_next[ridx] = 1'b0;
          end
        end
      end else begin
        if (hit_choke) begin
          on_next[ridx] = 1'b0;
        end
        if (on_c && (rd_data.grp == r_grp)) begin
          n_next = n + CNT_W'(1);
          if (!best_vld || (rd_data.pos > best_pos)) begin
            best_vld_next = 1'b1;
            best_next     = ridx;
            best_pos_next = rd_data.pos;
          end
        end
        if ((ridx == '0) || (rd_data.pos > steal_pos)) begin
          steal_next     = ridx;
          steal_pos_next = rd_data.pos;
        end
      end
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next    = S_SCAN;
          ptr_next      = '0;
          any_next      = 1'b0;
          n_next        = '0;
          best_vld_next = 1'b0;
        end
      end
      S_SCAN: begin
        rd_vld_next = 1'b1;
        ridx_next   = ptr;
        if (ptr == LAST) begin
          state_next = S_WAIT;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      S_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next      = S_IDLE;
        done_next       = 1'b1;
        slot_valid_next = 1'b0;
        slot_next       = '0;
        stole_next      = 1'b0;
        gain_next       = '0;
        any_out_next    = is_tick && any;
        if (!is_tick) begin
          on_next  = on_l;
          mask_src = on_l;
          if (go) begin
            on_next[target]  = 1'b1;
            mask_src[target] = 1'b1;
            wr_en            = 1'b1;
            wr_addr          = target;
            wr_data.pos      = '0;
            wr_data.len      = r_count;
            wr_data.grp      = r_grp;
            wr_data.addr     = r_base;
            wr_data.note     = r_note;
            wr_data.gain     = {1'b0, GAIN_Q15[vel_sat]};
            slot_valid_next  = 1'b1;
            slot_next        = tgt_wide[SLOT_W-1:0];
            stole_next       = !have_free;
            gain_next        = GAIN_Q15[vel_sat];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Result strobe comes only out of the finish step
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("result strobe without finish step");

  // Finish is always followed by the result strobe and idle in the next cycle
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (done && state == S_IDLE))
    else $error("finish step did not return to idle");

  // Returned data always matches an issued read
  a_rd_vld: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(rd_en))
    else $error("read data flagged without a read");

  // Memory is written only while a request is in work
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_IDLE))
    else $error("voice memory written while idle");
`endif

endmodule

`default_nettype wire

/* hdl/sample_voice_allocator_core.sv */
`default_nettype none

// Sample voice allocator. A request is taken when start is high and busy
// is low; each request (trigger or tick) yields exactly one result, shown
// for a single cycle with done high, and the receiver cannot stall it.
// A request keeps busy high through a registered read of the voice memory
// per voice, a wait for the last read to return, and a finish step that,
// for a trigger, applies the group limit, picks the slot and writes the new
// voice. The result appears in the cycle after the finish step, when busy is
// already low. No clearing pass is needed after reset: the active flags live
// in flip-flops and a memory entry's contents matter only while its voice is
// active.

module sample_voice_allocator_core #(
  parameter int VOICE_COUNT = svac_pkg::VOICE_COUNT_DEF,
  parameter int CHUNK_STEP  = svac_pkg::CHUNK_STEP_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd,
  input  wire logic [31:0]       sample_base,
  input  wire logic [23:0]       sample_count,
  input  wire logic [7:0]        velocity,
  input  wire logic signed [7:0] note_number,
  input  wire logic signed [8:0] voice_group,
  input  wire logic signed [8:0] choke_group,
  input  wire logic [3:0]        group_limit,
  input  wire logic              silence_only,
  output logic                   done,
  output logic                   slot_valid,
  output logic [3:0]             voice_slot,
  output logic                   stole_voice,
  output logic [14:0]            gain_q15,
  output logic                   any_active,
  output logic [11:0]            active_mask
);
  import svac_pkg::*;

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  voice_rec_t       rd_data, wr_data;

  // Voice record store
  svac_voice_mem #(
    .VOICE_COUNT (VOICE_COUNT),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Scan and update sequencer
  svac_seq #(
    .VOICE_COUNT (VOICE_COUNT),
    .CHUNK_STEP  (CHUNK_STEP),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .sample_base  (sample_base),
    .sample_count (sample_count),
    .velocity     (velocity),
    .note_number  (note_number),
    .voice_group  (voice_group),
    .choke_group  (choke_group),
    .group_limit  (group_limit),
    .silence_only (silence_only),
    .done         (done),
    .slot_valid   (slot_valid),
    .voice_slot   (voice_slot),
    .stole_voice  (stole_voice),
    .gain_q15     (gain_q15),
    .any_active   (any_active),
    .active_mask  (active_mask),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

endmodule

`default_nettype wire
